// File: rtl/core/mls_pkg.sv
`timescale 1ns / 1ps
// mls_pkg: shared types and constants for the MPLS label stack engine.
// No dependencies; imported by every module of the block except mls_ring_mem.
package mls_pkg;

    // Opcodes
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_SWAP  = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_PEEK  = 3'd3;
    localparam logic [2:0] OP_SER   = 3'd4;
    localparam logic [2:0] OP_PARSE = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam int BOS_BIT    = 8;   // bottom-of-stack flag in a shim word
    localparam int WORD_BYTES = 4;
    localparam int TALLY_MAX  = 63;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] shim_word;
        logic        buffer_start;
        logic        buffer_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] data_word;
        logic        last;
        logic [3:0]  entry_count;
        logic        empty_res;
        logic        broken;
        logic [1:0]  status;
        logic [5:0]  parsed_bytes;
    } t_out_item;

endpackage

// File: rtl/core/mpls_label_stack_engine.sv
`timescale 1ns / 1ps
// mpls_label_stack_engine: top level of the MPLS label stack engine.
// Instantiates mls_seq and mls_ring_mem; uses mls_pkg types.
//
// A bounded stack of 32-bit MPLS shim words held in a ring memory
// with registered reads. Push, swap, peek and parse-word transactions
// need no memory read, since the top entry is cached in a register.
// A pop that leaves entries behind reads the new top back from the
// ring (state S_POP) before the result is issued. Serialize streams
// the stack top first, one word per cycle while the output has space,
// after a read lead-in; bit 8 is set on the bottom word, which carries
// last. The sequencer takes one input
// transaction at a time and holds the input channel while a pop or
// serialize read is in flight, so a write and a read of the same ring
// entry never overlap. Results pass through an output register with a
// skid stage: a new input transaction is taken while one result still
// waits downstream. Parse words are inserted below the current bottom;
// the parse ends at the first word with bit 8 set (stored with bit 8
// cleared, broken flag cleared), at buffer_end, or when the stack is
// full. The ring contents come up undefined after reset; only entries
// below the depth are ever read, so no clearing pass is needed.
module mpls_label_stack_engine #(
    parameter int STACK_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mls_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mls_pkg::t_out_item o_out_item
);
    import mls_pkg::*;

    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic          space;
    logic          emit;
    t_out_item     res;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_data;

    // output register plus skid stage
    logic          r_out_valid;
    t_out_item     r_out;
    logic          r_skid_valid;
    t_out_item     r_skid;
    logic          pop;

    mls_seq #(
        .N  (STACK_DEPTH),
        .IW (IW),
        .CW (CW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_space    (space),
        .o_emit     (emit),
        .o_res      (res),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    mls_ring_mem #(
        .DEPTH (STACK_DEPTH),
        .IW    (IW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // a new result always fits while the skid stage is empty
    assign space = !r_skid_valid;
    assign pop   = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= emit;
            end else begin
                r_out_valid  <= emit;
            end
        end else if (emit) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (emit) begin
                    r_skid <= res;
                end
            end else if (emit) begin
                r_out <= res;
            end
        end else if (emit) begin
            if (r_out_valid) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: rtl/core/mls_ring_mem.sv
`timescale 1ns / 1ps
// mls_ring_mem: entry ring storage, one write and one read port,
// registered read data. No package dependencies.
module mls_ring_mem #(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/mls_seq.sv
`timescale 1ns / 1ps
// mls_seq: stack sequencer. Holds the stack pointers, parse state and a
// cached top word; drives the ring memory ports. Depends on mls_pkg.
module mls_seq #(
    parameter int N  = 8,
    parameter int IW = 3,
    parameter int CW = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mls_pkg::t_in_item i_in_item,
    input  logic              i_space,
    output logic              o_emit,
    output mls_pkg::t_out_item o_res,
    output logic              o_wr_en,
    output logic [IW-1:0]     o_wr_addr,
    output logic [31:0]       o_wr_data,
    output logic              o_rd_en,
    output logic [IW-1:0]     o_rd_addr,
    input  logic [31:0]       i_rd_data
);
    import mls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SER  = 3'b100
    } t_seq_state;

    localparam logic [CW-1:0] DEPTH_C = CW'(N);
    localparam logic [CW:0]   WRAP_C  = (CW+1)'(N);

    t_seq_state    r_state, n_state;
    logic [IW-1:0] r_bottom, n_bottom;
    logic [CW-1:0] r_depth, n_depth;
    logic          r_broken, n_broken;
    logic          r_parse, n_parse;
    logic [5:0]    r_tally, n_tally;
    logic [31:0]   r_top, n_top;
    logic [IW-1:0] r_pos, n_pos;

    logic          accept;
    logic          full;
    logic          parse_on;
    logic [5:0]    tally_base;
    logic [IW-1:0] below_bottom;
    logic [31:0]   clean_word;
    logic [31:0]   res_data;
    logic          res_last;
    logic [1:0]    res_status;
    logic          ser_override;

    // ring slot = (base + off) mod N; both terms below N
    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= WRAP_C) begin
            s = s - WRAP_C;
        end
        return IW'(s);
    endfunction

    assign o_in_ready   = (r_state == S_IDLE) && i_space;
    assign accept       = i_in_valid && o_in_ready;
    assign full         = (r_depth == DEPTH_C);
    assign parse_on     = r_parse || i_in_item.buffer_start;
    assign tally_base   = i_in_item.buffer_start ? 6'd0 : r_tally;
    assign below_bottom = (r_bottom == '0) ? IW'(N - 1) : r_bottom - IW'(1);
    assign clean_word   = i_in_item.shim_word & ~(32'd1 << BOS_BIT);

    always_comb begin
        n_state      = r_state;
        n_bottom     = r_bottom;
        n_depth      = r_depth;
        n_broken     = r_broken;
        n_parse      = r_parse;
        n_tally      = r_tally;
        n_top        = r_top;
        n_pos        = r_pos;
        o_wr_en      = 1'b0;
        o_wr_addr    = f_slot(r_bottom, r_depth);
        o_wr_data    = i_in_item.shim_word;
        o_rd_en      = 1'b0;
        o_rd_addr    = f_slot(r_bottom, r_depth - CW'(1));
        o_emit       = 1'b0;
        res_status   = ST_OK;
        ser_override = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_item.opcode)
                        OP_PUSH: begin
                            o_emit = 1'b1;
                            if (full) begin
                                res_status = ST_FULL;
                            end else begin
                                o_wr_en = 1'b1;
                                n_depth = r_depth + CW'(1);
                                n_top   = i_in_item.shim_word;
                            end
                        end
                        OP_SWAP: begin
                            o_emit  = 1'b1;
                            o_wr_en = 1'b1;
                            n_top   = i_in_item.shim_word;
                            if (r_depth == '0) begin
                                o_wr_addr = r_bottom;
                                n_depth   = CW'(1);
                            end else begin
                                o_wr_addr = f_slot(r_bottom, r_depth - CW'(1));
                            end
                        end
                        OP_POP: begin
                            if (r_depth == '0) begin
                                o_emit     = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                n_depth = r_depth - CW'(1);
                                if (r_depth == CW'(1)) begin
                                    o_emit = 1'b1;
                                end else begin
                                    // new top comes back from the ring next cycle
                                    o_rd_en   = 1'b1;
                                    o_rd_addr = f_slot(r_bottom, r_depth - CW'(2));
                                    n_state   = S_POP;
                                end
                            end
                        end
                        OP_SER: begin
                            if (r_depth == '0) begin
                                o_emit     = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                o_rd_en = 1'b1;
                                n_pos   = IW'(r_depth - CW'(1));
                                n_state = S_SER;
                            end
                        end
                        OP_PARSE: begin
                            o_emit = 1'b1;
                            if (i_in_item.buffer_start) begin
                                n_broken = 1'b1;
                                n_parse  = 1'b1;
                                n_tally  = 6'd0;
                            end
                            if (!parse_on) begin
                                res_status = ST_IGNORED;
                            end else begin
                                n_tally = (tally_base > 6'(TALLY_MAX - WORD_BYTES)) ?
                                          6'(TALLY_MAX) : tally_base + 6'(WORD_BYTES);
                                if (full) begin
                                    n_parse    = 1'b0;
                                    res_status = ST_FULL;
                                end else begin
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = below_bottom;
                                    o_wr_data = clean_word;
                                    n_bottom  = below_bottom;
                                    n_depth   = r_depth + CW'(1);
                                    if (r_depth == '0) begin
                                        n_top = clean_word;
                                    end
                                    if (i_in_item.shim_word[BOS_BIT]) begin
                                        n_broken = 1'b0;
                                        n_parse  = 1'b0;
                                    end
                                    if (i_in_item.buffer_end) begin
                                        n_parse = 1'b0;
                                    end
                                end
                            end
                        end
                        default: begin
                            // peek and unused codes
                            o_emit = 1'b1;
                            if (r_depth == '0) begin
                                res_status = ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_POP: begin
                if (i_space) begin
                    o_emit  = 1'b1;
                    n_top   = i_rd_data;
                    n_state = S_IDLE;
                end
            end
            S_SER: begin
                if (i_space) begin
                    o_emit       = 1'b1;
                    ser_override = 1'b1;
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = f_slot(r_bottom, CW'(r_pos - IW'(1)));
                        n_pos     = r_pos - IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ser_override) begin
            res_data = (r_pos == '0) ? (i_rd_data | (32'd1 << BOS_BIT)) : i_rd_data;
            res_last = (r_pos == '0);
        end else begin
            res_data = (n_depth == '0) ? 32'd0 : n_top;
            res_last = 1'b1;
        end
        // read address for the first serialize word
        if (r_state == S_IDLE && accept && i_in_item.opcode == OP_SER) begin
            o_rd_addr = f_slot(r_bottom, r_depth - CW'(1));
        end
    end

    always_comb begin
        o_res.data_word    = res_data;
        o_res.last         = res_last;
        o_res.entry_count  = 4'(n_depth);
        o_res.empty_res    = (n_depth == '0);
        o_res.broken       = n_broken;
        o_res.status       = res_status;
        o_res.parsed_bytes = n_tally;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bottom <= '0;
            r_depth  <= '0;
            r_broken <= 1'b0;
            r_parse  <= 1'b0;
            r_tally  <= '0;
        end else begin
            r_state  <= n_state;
            r_bottom <= n_bottom;
            r_depth  <= n_depth;
            r_broken <= n_broken;
            r_parse  <= n_parse;
            r_tally  <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_pos <= n_pos;
    end

endmodule

// File: rtl/core/mls_checker.sv
`timescale 1ns / 1ps
// mls_checker: port-level assertions for mpls_label_stack_engine, bound
// to the top level below. Depends on mls_pkg.
module mls_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input mls_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mls_pkg::t_out_item o_out_item
);
    import mls_pkg::*;

    // a waiting input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_item)))
        else $error("input transaction changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    // an empty stack reports a zero word and zero count
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.empty_res) |->
        (o_out_item.data_word == 32'd0 && o_out_item.entry_count == 4'd0))
        else $error("empty result with nonzero word or count");

    // only the inner words of a serialize run are not last
    a_inner_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |->
        (o_out_item.status == ST_OK && !o_out_item.empty_res))
        else $error("non-last result with bad status or empty stack");

    // byte tally moves in whole words and saturates
    a_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        (o_out_item.parsed_bytes[1:0] == 2'd0 || o_out_item.parsed_bytes == 6'd63))
        else $error("byte tally off word grid");

endmodule

bind mpls_label_stack_engine mls_checker u_mls_checker (.*);
